/* hw/rtl/cdq_pkg.sv */
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants for the circular deque
// Holds the operation codes, status codes, register map and the request,
// result and cell control types.
// ----------------------------------------------------------------------------
package cdq_pkg;

	typedef enum logic [1:0] {
		FUNC_PUSH_FRONT = 2'd0,
		FUNC_PUSH_BACK  = 2'd1,
		FUNC_POP_FRONT  = 2'd2,
		FUNC_POP_BACK   = 2'd3
	} cdq_func_t;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// Register word index of the capacity register.
	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		cdq_func_t   func;
		logic [31:0] item_value;
	} cdq_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] popped_value;
		logic        now_empty;
		logic        now_full;
	} cdq_res_t;

	// Command broadcast to every cell of the chain for one cycle.
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
		logic clear;
	} cdq_ctl_t;

endpackage

/* hw/rtl/circular_deque_core.sv */
// ----------------------------------------------------------------------------
// circular_deque_core: double-ended queue built from a chain of element cells
// Push and pop at either end, with a configurable capacity of 1 to DEPTH.
// ----------------------------------------------------------------------------
// One operation is accepted in every clock cycle and busy stays low; the
// result of each transfer appears in the next cycle for exactly one cycle with
// done high, and the receiver cannot stall it. Every element occupies one
// cell; a front push or pop shifts the whole chain by one cell in that cycle,
// and a back pop selects the last valid cell, so the pop-back path through
// the OR tree over DEPTH cells sets the clock rate. A push into a full deque
// returns status full and a pop from an empty deque returns status empty;
// neither changes the contents. Writing the capacity register empties the
// deque; only pwdata[4:0] is used: 0 acts as 1, a value above DEPTH as DEPTH.
module circular_deque_core
	import cdq_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cdq_req_t    req,
	output logic        done,
	output cdq_res_t    res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]         cap_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_n;
	logic                  done_q;
	cdq_res_t              res_q;
	cdq_res_t              res_n;
	cdq_ctl_t              ctl;
	logic                  cfg_wr;
	logic [CW-1:0]         cap_wr;
	logic                  accept;
	logic                  is_full;
	logic                  is_empty;
	logic [DATA_WIDTH-1:0] item_w;
	logic [DATA_WIDTH-1:0] popped_w;
	logic [DATA_WIDTH-1:0] back_w;
	logic [DEPTH-1:0]      valid_w;
	logic [DATA_WIDTH-1:0] data_w [DEPTH];
	logic [DATA_WIDTH-1:0] tap_w  [DEPTH];

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign accept = start & ~busy;
	assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_CAPACITY);
	assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(cap_q) : 32'd0;

	// Clamp the written capacity into the supported range.
	always_comb begin
		if (pwdata[4:0] == 5'd0) begin
			cap_wr = CW'(1);
		end else if (int'(pwdata[4:0]) > DEPTH) begin
			cap_wr = CW'(DEPTH);
		end else begin
			cap_wr = CW'(pwdata[4:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CW'(DEPTH);
		end else if (cfg_wr) begin
			cap_q <= cap_wr;
		end
	end

	assign is_full  = (count_q == cap_q);
	assign is_empty = (count_q == '0);
	assign item_w   = DATA_WIDTH'(req.item_value);

	always_comb begin
		ctl      = '0;
		ctl.clear = cfg_wr;
		count_n  = count_q;
		popped_w = '0;
		res_n    = '0;
		if (accept) begin
			case (req.func)
				FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
					if (is_full) begin
						res_n.status = STATUS_FULL;
					end else begin
						ctl.push_front = (req.func == FUNC_PUSH_FRONT);
						ctl.push_back  = (req.func == FUNC_PUSH_BACK);
						count_n        = count_q + CW'(1);
					end
				end
				FUNC_POP_FRONT, FUNC_POP_BACK: begin
					if (is_empty) begin
						res_n.status = STATUS_EMPTY;
					end else begin
						ctl.pop_front = (req.func == FUNC_POP_FRONT);
						ctl.pop_back  = (req.func == FUNC_POP_BACK);
						popped_w      = (req.func == FUNC_POP_FRONT) ? data_w[0] : back_w;
						count_n       = count_q - CW'(1);
					end
				end
				default: begin
					res_n.status = STATUS_DONE;
				end
			endcase
		end
		res_n.popped_value = 32'(64'(popped_w));
		res_n.now_empty    = (count_n == '0);
		res_n.now_full     = (count_n == cap_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= cfg_wr ? '0 : count_n;
			done_q  <= accept;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_n;
	end

	assign done = done_q;
	assign res  = res_q;

	// At most one cell is the back of the chain, so a plain OR selects it.
	always_comb begin
		back_w = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_w = back_w | tap_w[i];
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic                  lv;
		logic [DATA_WIDTH-1:0] ld;
		logic                  rv;
		logic [DATA_WIDTH-1:0] rd;

		if (g == 0) begin : g_first
			assign lv = 1'b1;
			assign ld = item_w;
		end else begin : g_inner_l
			assign lv = valid_w[g-1];
			assign ld = data_w[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign rv = 1'b0;
			assign rd = '0;
		end else begin : g_inner_r
			assign rv = valid_w[g+1];
			assign rd = data_w[g+1];
		end

		cdq_cell #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.item       (item_w),
			.left_valid (lv),
			.left_data  (ld),
			.right_valid(rv),
			.right_data (rd),
			.valid      (valid_w[g]),
			.data       (data_w[g]),
			.tap        (tap_w[g])
		);
	end

	// The chain's valid bits must agree with the element count.
	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_w) == int'(count_q))
		else $error("cell valid bits disagree with element count");

	a_count_within_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("element count exceeds capacity");

	a_full_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.status == STATUS_FULL) |-> res_q.now_full)
		else $error("push refused as full while deque not full");

	a_empty_refusal: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.status == STATUS_EMPTY) |-> res_q.now_empty)
		else $error("pop refused as empty while deque not empty");

endmodule

/* hw/rtl/cdq_cell.sv */
// ----------------------------------------------------------------------------
// cdq_cell: one element slot of the deque chain
// Holds one element and its valid bit. Pushes at the front shift the chain
// toward the back, pops at the front shift it toward the front, and the back
// end is found locally as the last valid cell.
// ----------------------------------------------------------------------------
module cdq_cell
	import cdq_pkg::*;
#(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cdq_ctl_t              ctl,
	input  logic [DATA_WIDTH-1:0] item,
	input  logic                  left_valid,
	input  logic [DATA_WIDTH-1:0] left_data,
	input  logic                  right_valid,
	input  logic [DATA_WIDTH-1:0] right_data,
	output logic                  valid,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] tap
);

	logic                  valid_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic                  is_back;
	logic                  is_next_free;

	assign is_back      = valid_q & ~right_valid;
	assign is_next_free = ~valid_q & left_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.push_front) begin
			valid_q <= left_valid;
		end else if (ctl.pop_front) begin
			valid_q <= right_valid;
		end else if (ctl.push_back && is_next_free) begin
			valid_q <= 1'b1;
		end else if (ctl.pop_back && is_back) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			data_q <= left_data;
		end else if (ctl.pop_front) begin
			data_q <= right_data;
		end else if (ctl.push_back && is_next_free) begin
			data_q <= item;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;
	// Only the back cell drives its element onto the shared OR tree.
	assign tap   = is_back ? data_q : '0;

endmodule
